@@ design/vlc_pkg.sv @@
// Shared types and codes for the value list with compaction.
package vlc_pkg;

  localparam int unsigned VALUE_W = 32;

  // Command codes
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_POP       = 3'd1;
  localparam logic [2:0] OP_REM_FIRST = 3'd2;
  localparam logic [2:0] OP_REM_ALL   = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [VALUE_W-1:0] value;
    logic [3:0]                index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [4:0]                count;
    logic [4:0]                removed_count;
    logic signed [VALUE_W-1:0] read_value;
  } out_item_t;

  // Controls for each cell of the chain: shift and write
  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

@@ design/value_list_with_compaction_top.sv @@
// Top level of the value list with compaction: cell ring plus sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transfer: append, pop, remove first match, remove all matches, clear or
//   read. Result channel (out_valid / out_stall / out_data) returns exactly
//   one result per command, in command order.
//   Append, pop, clear, unused codes and rejected commands go from transfer
//   through the finish state into the output register; remove and in-range
//   read pass through the scan state first. The entries sit in a ring of
//   DEPTH cells; remove and read rotate the ring once around, one cell per
//   cycle. A new command is taken once the previous one has moved its result
//   into the output register.
//   While the receiver stalls, the result holds in the output register and
//   the next command still runs; it then waits in its finish state for the
//   register to free up.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result. Cell contents stay undefined until written; no clearing pass.
module value_list_with_compaction_top #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vlc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vlc_pkg::out_item_t  out_data
);

  localparam int IW = $clog2(DEPTH);

  // Cell outputs around the ring; cell 0 is the head seen by the sequencer
  logic signed [vlc_pkg::VALUE_W-1:0] cell_value [DEPTH];

  vlc_pkg::cell_ctl_t                 ctl;
  logic [IW-1:0]                      wr_addr;
  logic signed [vlc_pkg::VALUE_W-1:0] wr_data;

  vlc_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (cell_value[0]),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    vlc_pkg::cell_ctl_t cell_ctl;

    // Shift goes to every cell; the write strobe lands only on the addressed one
    always_comb begin
      cell_ctl.shift = ctl.shift;
      cell_ctl.write = ctl.write && (wr_addr == IW'(i));
    end

    vlc_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .nbr_value (cell_value[(i + 1) % DEPTH]),
      .wr_data   (wr_data),
      .value     (cell_value[i])
    );
  end

endmodule

@@ design/vlc_cell.sv @@
// One storage cell of the list chain: hold, take the right neighbor, or load.
module vlc_cell (
  input  logic                                clk,
  input  vlc_pkg::cell_ctl_t                  ctl,
  input  logic signed [vlc_pkg::VALUE_W-1:0]  nbr_value,
  input  logic signed [vlc_pkg::VALUE_W-1:0]  wr_data,
  output logic signed [vlc_pkg::VALUE_W-1:0]  value
);

  logic signed [vlc_pkg::VALUE_W-1:0] value_r;
  logic signed [vlc_pkg::VALUE_W-1:0] value_nxt;

  always_comb begin
    if (ctl.write) begin
      value_nxt = wr_data;
    end else if (ctl.shift) begin
      value_nxt = nbr_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ design/vlc_ctrl.sv @@
// Command sequencer, fill count, scan pointers and result register.
module vlc_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  vlc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vlc_pkg::out_item_t                  out_data,
  input  logic signed [vlc_pkg::VALUE_W-1:0]  head,
  output vlc_pkg::cell_ctl_t                  ctl,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic signed [vlc_pkg::VALUE_W-1:0]  wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int XW = (IW > 4) ? IW : 4;
  localparam int YW = (CW > 4) ? CW : 4;

  vlc_pkg::state_t state_r, state_nxt;

  logic [2:0]                        op_r, op_nxt;
  logic signed [vlc_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [3:0]                        idx_r, idx_nxt;
  logic [IW-1:0]                     step_r, step_nxt;
  logic [CW-1:0]                     wptr_r, wptr_nxt;
  logic [CW-1:0]                     fill_r, fill_nxt;
  logic                              hit_r, hit_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic [CW-1:0]                     removed_r, removed_nxt;
  logic signed [vlc_pkg::VALUE_W-1:0] rdval_r, rdval_nxt;
  logic                              out_valid_r, out_valid_nxt;
  vlc_pkg::out_item_t                out_data_r, out_data_nxt;

  logic          accept;
  logic          last_step;
  logic          in_list;
  logic          drop;
  logic [PW-1:0] phys;

  assign accept    = in_valid && (state_r == vlc_pkg::S_IDLE);
  assign in_stall  = (state_r != vlc_pkg::S_IDLE);
  assign last_step = (step_r == IW'(DEPTH - 1));
  assign in_list   = (CW'(step_r) < fill_r);
  assign drop      = in_list && (head == val_r) &&
                     ((op_r == vlc_pkg::OP_REM_ALL) || !hit_r);
  // Physical cell of logical slot wptr once this cycle's rotation lands
  assign phys      = PW'(DEPTH) + PW'(wptr_r) - PW'(step_r) - PW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vlc_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            vlc_pkg::OP_REM_FIRST: begin
              state_nxt = (fill_r == '0) ? vlc_pkg::S_FIN : vlc_pkg::S_SCAN;
            end
            vlc_pkg::OP_REM_ALL: begin
              state_nxt = vlc_pkg::S_SCAN;
            end
            vlc_pkg::OP_READ: begin
              state_nxt = (YW'(in_data.index) < YW'(fill_r)) ?
                          vlc_pkg::S_SCAN : vlc_pkg::S_FIN;
            end
            default: begin
              state_nxt = vlc_pkg::S_FIN;
            end
          endcase
        end
      end
      vlc_pkg::S_SCAN: begin
        if (last_step) begin
          state_nxt = vlc_pkg::S_FIN;
        end
      end
      vlc_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = vlc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vlc_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and cell controls
  always_comb begin
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    hit_nxt       = hit_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    rdval_nxt     = rdval_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    wr_addr       = fill_r[IW-1:0];
    wr_data       = in_data.value;

    case (state_r)
      vlc_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt      = in_data.opcode;
          val_nxt     = in_data.value;
          idx_nxt     = in_data.index;
          step_nxt    = '0;
          wptr_nxt    = '0;
          hit_nxt     = 1'b0;
          status_nxt  = vlc_pkg::ST_OK;
          removed_nxt = '0;
          rdval_nxt   = '0;
          case (in_data.opcode)
            vlc_pkg::OP_APPEND: begin
              if (fill_r == CW'(DEPTH)) begin
                status_nxt = vlc_pkg::ST_FULL;
              end else begin
                ctl.write = 1'b1;
                fill_nxt  = fill_r + CW'(1);
              end
            end
            vlc_pkg::OP_POP: begin
              if (fill_r == '0) begin
                status_nxt = vlc_pkg::ST_EMPTY;
              end else begin
                fill_nxt    = fill_r - CW'(1);
                removed_nxt = CW'(1);
              end
            end
            vlc_pkg::OP_REM_FIRST: begin
              if (fill_r == '0) begin
                status_nxt = vlc_pkg::ST_EMPTY;
              end
            end
            vlc_pkg::OP_CLEAR: begin
              removed_nxt = fill_r;
              fill_nxt    = '0;
            end
            vlc_pkg::OP_READ: begin
              if (YW'(in_data.index) >= YW'(fill_r)) begin
                status_nxt = vlc_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      vlc_pkg::S_SCAN: begin
        // Rotate the ring one cell per cycle; the head visits logical slot step_r
        ctl.shift = 1'b1;
        wr_addr   = phys[IW-1:0];
        wr_data   = head;
        step_nxt  = step_r + IW'(1);
        if (op_r == vlc_pkg::OP_READ) begin
          if (XW'(step_r) == XW'(idx_r)) begin
            rdval_nxt = head;
          end
        end else if (drop) begin
          hit_nxt = 1'b1;
        end else if (in_list) begin
          ctl.write = 1'b1;
          wptr_nxt  = wptr_r + CW'(1);
        end
        if (last_step && (op_r != vlc_pkg::OP_READ)) begin
          fill_nxt    = wptr_nxt;
          removed_nxt = fill_r - wptr_nxt;
        end
      end
      vlc_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.count         = 5'(fill_r);
          out_data_nxt.removed_count = 5'(removed_r);
          out_data_nxt.read_value    = rdval_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vlc_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    step_r     <= step_nxt;
    wptr_r     <= wptr_nxt;
    hit_r      <= hit_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    rdval_r    <= rdval_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != vlc_pkg::S_IDLE))
    else $error("accepted command did not start");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_wptr_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vlc_pkg::S_SCAN) |-> (wptr_r <= CW'(step_r)))
    else $error("write pointer ahead of scan pointer");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == vlc_pkg::S_FIN))
    else $error("result issued outside finish state");

endmodule

@@ sim/value_list_with_compaction_top_tb.sv @@
// Testbench for the value list with compaction: directed and random command traffic checked against a list model.
`timescale 1ns / 100ps

module value_list_with_compaction_top_tb;

  localparam int LIST_DEPTH       = 16;
  localparam int RANDOM_ITEMS     = 1000;
  localparam int LONG_HOLD_AT     = 300;   // result number that starts the long receiver hold
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any transfer while work is open
  localparam int SETTLE_CYCLES    = 40;    // tail after the last result
  localparam int MAX_REPORTS      = 50;

  // Opcodes the block leaves unused; they must change nothing
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] V_ONES = 32'shFFFF_FFFF;

  typedef struct {
    vlc_pkg::in_item_t cmd;
    int unsigned       gap;    // idle cycles before the command is offered
    bit                drain;  // hold the command until every result is back
  } queued_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  vlc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  vlc_pkg::out_item_t out_data;

  value_list_with_compaction_top #(.DEPTH(LIST_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List model: mirror of the entries and the fill count, advanced once per
  // accepted command, in command order.
  // ---------------------------------------------------------------------------
  logic signed [31:0] list_mem [LIST_DEPTH];
  int unsigned        list_len = 0;

  function automatic vlc_pkg::out_item_t list_apply(input vlc_pkg::in_item_t c);
    vlc_pkg::out_item_t r;
    int unsigned        w;
    r = '0;
    r.status = vlc_pkg::ST_OK;
    case (c.opcode)
      vlc_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = vlc_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = c.value;
          list_len++;
        end
      end
      vlc_pkg::OP_POP: begin
        if (list_len == 0) begin
          r.status = vlc_pkg::ST_EMPTY;
        end else begin
          list_len--;
          r.removed_count = 5'd1;
        end
      end
      vlc_pkg::OP_REM_FIRST: begin
        if (list_len == 0) begin
          r.status = vlc_pkg::ST_EMPTY;
        end else begin
          // compact in place: skip only the earliest match
          w = 0;
          for (int i = 0; i < list_len; i++) begin
            if (r.removed_count == 0 && list_mem[i] == c.value) begin
              r.removed_count = 5'd1;
            end else begin
              list_mem[w] = list_mem[i];
              w++;
            end
          end
          list_len = w;
        end
      end
      vlc_pkg::OP_REM_ALL: begin
        // an empty list simply yields nothing removed, status stays ok
        w = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == c.value) begin
            r.removed_count++;
          end else begin
            list_mem[w] = list_mem[i];
            w++;
          end
        end
        list_len = w;
      end
      vlc_pkg::OP_CLEAR: begin
        r.removed_count = 5'(list_len);
        list_len = 0;
      end
      vlc_pkg::OP_READ: begin
        if (c.index < list_len) begin
          r.read_value = list_mem[c.index];
        end else begin
          r.status = vlc_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command stream: built once at time zero, consumed by the driver.
  // ---------------------------------------------------------------------------
  queued_cmd_t        cmd_q[$];
  logic signed [31:0] val_pool [4];
  bit                 gen_quiet = 1'b0;
  bit                 gen_drain = 1'b0;

  task automatic push_cmd(input logic [2:0] op, input logic signed [31:0] val,
                          input logic [3:0] idx);
    queued_cmd_t q;
    q.cmd.opcode = op;
    q.cmd.value  = val;
    q.cmd.index  = idx;
    q.gap        = gen_quiet ? 0 : $urandom_range(0, 15);
    q.drain      = gen_drain;
    gen_drain    = 1'b0;
    cmd_q.push_back(q);
  endtask

  function automatic logic [3:0] pick_idx();
    return 4'($urandom_range(0, 15));
  endfunction

  // Mostly reuse the small pool so removals find matches; now and then a fresh word
  function automatic logic signed [31:0] pick_val();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return val_pool[$urandom_range(0, 3)];
  endfunction

  task automatic refill_pool();
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0: val_pool[i] = $urandom;
        1: val_pool[i] = $urandom_range(0, 7) - 3;
        2: val_pool[i] = $urandom_range(0, 1) ? V_MAX : V_MIN;
        default: val_pool[i] = $urandom_range(0, 1) ? V_ONES : '0;
      endcase
    end
  endtask

  task automatic build_directed();
    // Empty list: out-of-range read, ignored pop and remove-first,
    // remove-all and clear with nothing to do, spare opcodes
    push_cmd(vlc_pkg::OP_READ, '0, 4'd0);
    push_cmd(vlc_pkg::OP_POP, '0, 4'd0);
    push_cmd(vlc_pkg::OP_REM_FIRST, V_MAX, 4'd0);
    push_cmd(vlc_pkg::OP_REM_ALL, V_MIN, 4'd0);
    push_cmd(vlc_pkg::OP_CLEAR, '0, 4'd0);
    push_cmd(OP_SPARE6, V_ONES, 4'd15);
    push_cmd(OP_SPARE7, V_MIN, 4'd7);
    // Field extremes, with a duplicate of the maximum
    push_cmd(vlc_pkg::OP_APPEND, V_MIN, 4'd0);
    push_cmd(vlc_pkg::OP_APPEND, V_MAX, 4'd0);
    push_cmd(vlc_pkg::OP_APPEND, '0, 4'd0);
    push_cmd(vlc_pkg::OP_APPEND, V_ONES, 4'd0);
    push_cmd(vlc_pkg::OP_APPEND, V_MAX, 4'd0);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd0);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd1);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd3);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd15);
    // Remove-first takes only the earlier duplicate; the rest shifts down
    push_cmd(vlc_pkg::OP_REM_FIRST, V_MAX, 4'd0);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd1);
    // No match on either removal
    push_cmd(vlc_pkg::OP_REM_ALL, 32'sd5, 4'd0);
    push_cmd(vlc_pkg::OP_REM_FIRST, 32'sd12345, 4'd0);
    // Remove-all with two matches, then pop and a clear of what is left
    push_cmd(vlc_pkg::OP_APPEND, '0, 4'd0);
    push_cmd(vlc_pkg::OP_REM_ALL, '0, 4'd0);
    push_cmd(vlc_pkg::OP_POP, '0, 4'd0);
    push_cmd(vlc_pkg::OP_CLEAR, '0, 4'd0);
    push_cmd(vlc_pkg::OP_READ, '0, 4'd0);
  endtask

  task automatic build_random();
    int seq;
    int n;
    seq = 0;
    while (cmd_q.size() < RANDOM_ITEMS + 25) begin
      gen_quiet = ($urandom_range(0, 3) == 0);
      gen_drain = (seq % 8 == 0);  // the first sequence always starts from an idle block
      refill_pool();
      if (seq == 0 || $urandom_range(0, 9) < 8) begin
        // Well-formed: optional clear, a fill run, then work on the filled list.
        // The first run always overfills to hit the dropped append.
        if (seq == 0 || $urandom_range(0, 1) == 1)
          push_cmd(vlc_pkg::OP_CLEAR, $urandom, pick_idx());
        if (seq == 0) n = 18;
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(15, 18);
        else n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          push_cmd(vlc_pkg::OP_APPEND, pick_val(), pick_idx());
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0, 1, 6: push_cmd(vlc_pkg::OP_READ, $urandom, pick_idx());
            2, 7:    push_cmd(vlc_pkg::OP_REM_FIRST, pick_val(), pick_idx());
            3:       push_cmd(vlc_pkg::OP_REM_ALL, pick_val(), pick_idx());
            4:       push_cmd(vlc_pkg::OP_POP, $urandom, pick_idx());
            default: push_cmd(vlc_pkg::OP_APPEND, pick_val(), pick_idx());
          endcase
        end
      end else begin
        // Noise: any opcode, any value
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_cmd(3'($urandom_range(0, 7)), $urandom, pick_idx());
      end
      seq++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued commands, each after its own idle gap. A command
  // marked for drain waits until no transfer is in flight and every result
  // has come back. During the long receiver hold, skip the gaps so the
  // block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned tx_wait = 0;
  bit          tx_armed = 1'b0;
  bit          rx_long = 1'b0;
  int unsigned n_in = 0;   // commands transferred into the block
  int unsigned n_out = 0;  // results transferred out of the block

  always @(posedge clk) begin : drive_p
    int unsigned g;
    bit          armed;
    bit          may_go;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_wait  <= 0;
      tx_armed <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // Slot is free: any command on the bus transfers at this edge
      g     = tx_wait;
      armed = tx_armed;
      if (!armed && cmd_q.size() != 0) begin
        g     = rx_long ? 0 : cmd_q[0].gap;
        armed = 1'b1;
      end
      may_go = armed && g == 0;
      if (may_go && cmd_q[0].drain)
        may_go = !in_valid && n_in == n_out;
      if (may_go) begin
        in_data  <= cmd_q[0].cmd;
        in_valid <= 1'b1;
        void'(cmd_q.pop_front());
        armed = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (armed && g != 0) g--;
      end
      tx_wait  <= g;
      tx_armed <= armed;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each result transfer, draw a random stall, with quiet
  // stretches of no stall. Once, hold off for a long stretch.
  // ---------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  int unsigned rx_count = 0;
  bit          rx_quiet = 1'b0;

  always @(posedge clk) begin : recv_p
    int unsigned k;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      rx_count  <= 0;
      rx_quiet  <= 1'b0;
      rx_long   <= 1'b0;
    end else begin
      k = rx_wait;
      if (out_valid && !out_stall) begin
        if (rx_count == LONG_HOLD_AT) k = LONG_HOLD_CYCLES;
        else if (rx_quiet) k = 0;
        else k = $urandom_range(0, 15);
        if (rx_count % 64 == 63) rx_quiet <= ($urandom_range(0, 2) == 0);
        rx_count <= rx_count + 1;
      end else if (k != 0) begin
        k--;
      end
      rx_wait   <= k;
      out_stall <= (k != 0);
      rx_long   <= (k > 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the result transfer against the oldest pending prediction
  // first, then run the model on a command transfer at the same edge. A
  // command's own result can never arrive at its transfer edge.
  // ---------------------------------------------------------------------------
  vlc_pkg::out_item_t result_due_q[$];
  int unsigned        err_cnt = 0;
  int unsigned        op_cnt [8];
  int unsigned        status_cnt [4];

  task automatic report_field(input string fname, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      if (err_cnt < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                 $time, fname, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_p
    vlc_pkg::out_item_t want;
    vlc_pkg::out_item_t pred;
    if (!rst_n) begin
      n_in  <= 0;
      n_out <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_due_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: result with none pending, expected nothing, actual %p",
                     $time, out_data);
          err_cnt++;
        end else begin
          want = result_due_q.pop_front();
          report_field("status", 32'(want.status), 32'(out_data.status));
          report_field("count", 32'(want.count), 32'(out_data.count));
          report_field("removed_count", 32'(want.removed_count),
                       32'(out_data.removed_count));
          report_field("read_value", want.read_value, out_data.read_value);
        end
        n_out <= n_out + 1;
      end
      if (in_valid && !in_stall) begin
        pred = list_apply(in_data);
        result_due_q.push_back(pred);
        op_cnt[in_data.opcode]++;
        status_cnt[pred.status]++;
        n_in <= n_in + 1;
      end
    end
  end

  // Watchdog: count cycles with open work and no transfer on either channel
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin : watchdog_p
    if (rst_n && (cmd_q.size() != 0 || in_valid || n_in != n_out)
        && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("FAILURE");
        $finish;
      end
      stuck_cycles <= stuck_cycles + 1;
    end else begin
      stuck_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stream, release reset, wait for the last result and a
  // short tail, then report.
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Poll on the falling edge, away from the transfer edge
    while (cmd_q.size() != 0 || in_valid || n_in != n_out) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, result_due_q.size());
      err_cnt++;
    end
    $display("Covered %0d commands: append %0d, pop %0d, remove-first %0d, remove-all %0d,",
             n_in, op_cnt[vlc_pkg::OP_APPEND], op_cnt[vlc_pkg::OP_POP],
             op_cnt[vlc_pkg::OP_REM_FIRST], op_cnt[vlc_pkg::OP_REM_ALL]);
    $display("  clear %0d, read %0d, spare %0d; status ok %0d empty %0d full %0d range %0d",
             op_cnt[vlc_pkg::OP_CLEAR], op_cnt[vlc_pkg::OP_READ],
             op_cnt[OP_SPARE6] + op_cnt[OP_SPARE7],
             status_cnt[vlc_pkg::ST_OK], status_cnt[vlc_pkg::ST_EMPTY],
             status_cnt[vlc_pkg::ST_FULL], status_cnt[vlc_pkg::ST_RANGE]);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
